FILE: sv/mctf_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the midi clock tempo follower
// no dependencies

package mctf_pkg;

  localparam int WIN_DEPTH   = 8;
  localparam int TPQ         = 960;
  localparam int WIN_AW      = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
  localparam int FILL_W      = $clog2(WIN_DEPTH + 1);
  localparam int GAP_W       = 32;
  localparam int TICK_W      = 48;
  localparam int TEMPO_W     = 20;
  localparam int POS_W       = 7;
  localparam int VALUE_W     = 24;
  localparam int SUM_W       = GAP_W + WIN_AW;
  localparam int TEMPO_SCALE = TPQ / 24;
  localparam int LOC_SCALE   = TPQ / 4;
  localparam int PROD_W      = TEMPO_W + $clog2(TEMPO_SCALE + 1);
  localparam int DIV_W       = (SUM_W > PROD_W) ? SUM_W : PROD_W;
  localparam int CNT_W       = $clog2(DIV_W + 1);
  localparam int TEMPO_LIMIT = 500000;

  typedef enum logic [2:0] {
    EV_CLOCK    = 3'd0,
    EV_START    = 3'd1,
    EV_CONTINUE = 3'd2,
    EV_STOP     = 3'd3,
    EV_SONG_POS = 3'd4
  } event_kind_t;

  typedef enum logic [1:0] {
    CMD_TEMPO  = 2'd0,
    CMD_LOCATE = 2'd1,
    CMD_PLAY   = 2'd2,
    CMD_STOP   = 2'd3
  } command_t;

  typedef struct packed {
    logic accept;
    logic start_avg;
    logic start_bpm;
    logic load_tempo;
    logic load_play;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic              clock_unseen;
    logic              gap_zero;
    logic              div_done;
    logic              div_busy;
    logic              bpm_ok;
    logic              pend_last;
    logic              slot_free;
    logic [FILL_W-1:0] fill;
  } dp_status_t;

endpackage

FILE: sv/mctf_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
// depends on mctf_pkg

module mctf_div import mctf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [GAP_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [GAP_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [GAP_W-1:0] dvs_r, dvs_nxt;
  logic [GAP_W:0]   rem_sh;
  logic [GAP_W:0]   diff;
  logic             ge;

  assign rem_sh = {rem_r, quo_r[DIV_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};
  assign ge     = (rem_sh >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIV_W);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[GAP_W-1:0] : rem_sh[GAP_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: sv/mctf_dp.sv
`timescale 1ns / 1ps
// datapath: clock gap window, running sum, divider, pending and output registers
// depends on mctf_pkg and mctf_div

module mctf_dp import mctf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  input  logic [2:0]         in_kind,
  input  logic [TICK_W-1:0]  in_tick,
  input  logic [POS_W-1:0]   in_pos_low,
  input  logic [POS_W-1:0]   in_pos_high,
  input  logic [TEMPO_W-1:0] in_tempo,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_command,
  output logic [VALUE_W-1:0] out_value,
  output logic               out_last
);

  logic               seen_r, seen_nxt;
  logic [TICK_W-1:0]  prev_r, prev_nxt;
  logic [GAP_W-1:0]   win_r [WIN_DEPTH];
  logic [WIN_AW-1:0]  idx_r, idx_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [TEMPO_W-1:0] tempo_r, tempo_nxt;
  logic [1:0]         pcmd_r, pcmd_nxt;
  logic [VALUE_W-1:0] pval_r, pval_nxt;
  logic               plast_r, plast_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [1:0]         ocmd_r;
  logic [VALUE_W-1:0] oval_r;
  logic               olast_r;
  logic               win_we;

  logic [TICK_W-1:0]  tick_diff;
  logic [GAP_W-1:0]   gap;
  logic [SUM_W-1:0]   old_entry;
  logic [2*POS_W-1:0] pos;
  logic [DIV_W-1:0]   div_dividend;
  logic [GAP_W-1:0]   div_divisor;
  logic               div_busy, div_done;
  logic [DIV_W-1:0]   quo;
  logic               slot_free;

  assign tick_diff = in_tick - prev_r;
  assign gap       = tick_diff[GAP_W-1:0];
  assign old_entry = (fill_r == FILL_W'(WIN_DEPTH)) ? SUM_W'(win_r[idx_r]) : '0;
  assign pos       = {in_pos_high, in_pos_low};
  assign slot_free = !ovalid_r || out_ready;

  always_comb begin
    seen_nxt  = seen_r;
    prev_nxt  = prev_r;
    idx_nxt   = idx_r;
    fill_nxt  = fill_r;
    sum_nxt   = sum_r;
    tempo_nxt = tempo_r;
    pcmd_nxt  = pcmd_r;
    pval_nxt  = pval_r;
    plast_nxt = plast_r;
    win_we    = 1'b0;
    if (cmd.accept) begin
      tempo_nxt = in_tempo;
      unique case (in_kind)
        EV_CLOCK: begin
          seen_nxt = 1'b1;
          prev_nxt = in_tick;
          if (seen_r && (gap != '0)) begin
            win_we  = 1'b1;
            idx_nxt = (idx_r == WIN_AW'(WIN_DEPTH - 1)) ? '0 : idx_r + 1'b1;
            if (fill_r != FILL_W'(WIN_DEPTH)) fill_nxt = fill_r + 1'b1;
            sum_nxt = sum_r + SUM_W'(gap) - old_entry;
          end
        end
        EV_START: begin
          seen_nxt  = 1'b0;
          idx_nxt   = '0;
          fill_nxt  = '0;
          sum_nxt   = '0;
          pcmd_nxt  = CMD_LOCATE;
          pval_nxt  = '0;
          plast_nxt = 1'b0;
        end
        EV_CONTINUE: begin
          pcmd_nxt  = CMD_PLAY;
          pval_nxt  = '0;
          plast_nxt = 1'b1;
        end
        EV_STOP: begin
          pcmd_nxt  = CMD_STOP;
          pval_nxt  = '0;
          plast_nxt = 1'b1;
        end
        EV_SONG_POS: begin
          pcmd_nxt  = CMD_LOCATE;
          pval_nxt  = VALUE_W'(pos * LOC_SCALE);
          plast_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
    if (cmd.load_play) begin
      pcmd_nxt  = CMD_PLAY;
      pval_nxt  = '0;
      plast_nxt = 1'b1;
    end
    if (cmd.load_tempo) begin
      pcmd_nxt  = CMD_TEMPO;
      pval_nxt  = quo[VALUE_W-1:0];
      plast_nxt = 1'b1;
    end
  end

  // second division reuses the average as divisor, latched inside the divider
  always_comb begin
    if (cmd.start_bpm) begin
      div_dividend = DIV_W'(tempo_r * TEMPO_SCALE);
      div_divisor  = quo[GAP_W-1:0];
    end else begin
      div_dividend = DIV_W'(sum_r);
      div_divisor  = GAP_W'(fill_r);
    end
  end

  mctf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.start_avg || cmd.start_bpm),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (out_ready) ovalid_nxt = 1'b0;
    if (cmd.out_load) ovalid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r   <= 1'b0;
      prev_r   <= '0;
      idx_r    <= '0;
      fill_r   <= '0;
      sum_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      seen_r   <= seen_nxt;
      prev_r   <= prev_nxt;
      idx_r    <= idx_nxt;
      fill_r   <= fill_nxt;
      sum_r    <= sum_nxt;
      ovalid_r <= ovalid_nxt;
    end
    tempo_r <= tempo_nxt;
    pcmd_r  <= pcmd_nxt;
    pval_r  <= pval_nxt;
    plast_r <= plast_nxt;
    if (win_we) win_r[idx_r] <= gap;
    if (cmd.out_load) begin
      ocmd_r  <= pcmd_r;
      oval_r  <= pval_r;
      olast_r <= plast_r;
    end
  end

  always_comb begin
    status.kind         = in_kind;
    status.clock_unseen = !seen_r;
    status.gap_zero     = (gap == '0);
    status.div_done     = div_done;
    status.div_busy     = div_busy;
    status.bpm_ok       = (quo != '0) && (quo < DIV_W'(TEMPO_LIMIT));
    status.pend_last    = plast_r;
    status.slot_free    = slot_free;
    status.fill         = fill_r;
  end

  assign out_valid   = ovalid_r;
  assign out_command = ocmd_r;
  assign out_value   = oval_r;
  assign out_last    = olast_r;

endmodule

FILE: sv/mctf_ctrl.sv
`timescale 1ns / 1ps
// controller: sequences event handling, the two divisions and result emission
// depends on mctf_pkg

module mctf_ctrl import mctf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_AVG_ST, S_AVG, S_BPM_ST, S_BPM, S_EMIT, S_PLAY
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (status.kind)
            EV_CLOCK: begin
              if (!status.clock_unseen && !status.gap_zero) state_nxt = S_AVG_ST;
            end
            EV_START, EV_CONTINUE, EV_STOP, EV_SONG_POS: state_nxt = S_EMIT;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_AVG_ST: begin
        cmd.start_avg = 1'b1;
        state_nxt     = S_AVG;
      end
      S_AVG: begin
        if (status.div_done) state_nxt = S_BPM_ST;
      end
      S_BPM_ST: begin
        cmd.start_bpm = 1'b1;
        state_nxt     = S_BPM;
      end
      S_BPM: begin
        if (status.div_done) begin
          if (status.bpm_ok) begin
            cmd.load_tempo = 1'b1;
            state_nxt      = S_EMIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (status.slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = status.pend_last ? S_IDLE : S_PLAY;
        end
      end
      S_PLAY: begin
        cmd.load_play = 1'b1;
        state_nxt     = S_EMIT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/midi_clock_tempo_follower.sv
`timescale 1ns / 1ps
// midi beat clock follower: turns real-time events into tempo and transport commands
// path: stop, continue, song position and start go through the pending register to the output register
//   once the output slot is free; a clock that yields a tempo first runs both divisions, then takes the same path
// throughput: one event at a time; the shared serial divider runs twice per tempo update
// reset: rst_n synchronous active low clears transport state; the gap window is unset until written

module midi_clock_tempo_follower import mctf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,  // now_tick[47:0], position_low[54:48],
                                 // position_high[61:55], current_tempo_milli[81:62], zero fill
  input  logic [2:0]  in_tuser,  // event_kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // value[23:0]
  output logic [1:0]  out_tuser, // command[1:0]
  output logic        out_tlast  // last result caused by the input transaction
);

  dp_cmd_t    cmd;
  dp_status_t status;

  mctf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath holds the window, the running gap sum and the output register
  mctf_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_kind     (in_tuser),
    .in_tick     (in_tdata[47:0]),
    .in_pos_low  (in_tdata[54:48]),
    .in_pos_high (in_tdata[61:55]),
    .in_tempo    (in_tdata[81:62]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_command (out_tuser),
    .out_value   (out_tdata),
    .out_last    (out_tlast)
  );

  // window fill never passes the depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    status.fill <= FILL_W'(WIN_DEPTH))
    else $error("window fill beyond depth");

  // a tempo command always carries an in-range tempo
  a_tempo_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == CMD_TEMPO) |->
      (out_tdata != '0 && out_tdata < VALUE_W'(TEMPO_LIMIT)))
    else $error("tempo out of range");

  // a non-final locate comes only from start and points at zero
  a_start_locate: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tuser == CMD_LOCATE && out_tdata == '0))
    else $error("bad first result of start");

  // no event is taken while the divider is working
  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !status.div_busy)
    else $error("input ready while dividing");

endmodule
